// ===== src/lesc_pkg.sv =====
package lesc_pkg;

  localparam int USERS        = 16;
  localparam int FRAME_WINDOW = 16;
  localparam int SLOTS        = USERS * FRAME_WINDOW;
  localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int UIDX_W       = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int BYTE_BITS    = 8;
  localparam int ADD_W        = 16;
  localparam int CNT_W        = 32;
  localparam int SPB_W        = 12;
  localparam int CMDQ_DEPTH   = 2;
  localparam int RESQ_DEPTH   = 2;

  localparam logic [2:0] OP_BIT_ERR   = 3'd0;
  localparam logic [2:0] OP_DEC_BITS  = 3'd1;
  localparam logic [2:0] OP_BLK_ERR   = 3'd2;
  localparam logic [2:0] OP_DEC_BLK   = 3'd3;
  localparam logic [2:0] OP_REP_BITS  = 3'd4;
  localparam logic [2:0] OP_REP_SYMS  = 3'd5;
  localparam logic [2:0] OP_REP_TOTAL = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  user;
    logic [3:0]  win_slot;
    logic [7:0]  sent_byte;
    logic [7:0]  received_byte;
    logic [15:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0] error_count;
    logic [31:0] total_count;
    logic [3:0]  flipped_bits;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0]        op;
    logic              user_ok;
    logic              slot_ok;
    logic              blk_err;
    logic [UIDX_W-1:0] uidx;
    logic [IDX_W-1:0]  idx;
    logic [ADD_W-1:0]  addend;
    logic [3:0]        flipped;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [ADD_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W+1-ADD_W){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== src/lesc_front.sv =====
module lesc_front import lesc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_item_t         in_data,
  output logic             in_full,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SPB_W-1:0] cfg_data,
  output logic             q_push,
  output cmd_t             q_data,
  input  logic             q_full
);

  logic [SPB_W-1:0] spb_r;
  logic [SPB_W-1:0] spb_nxt;

  assign cfg_ready = 1'b1;
  assign spb_nxt   = (cfg_valid && cfg_ready) ? cfg_data : spb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r <= '0;
    end else begin
      spb_r <= spb_nxt;
    end
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    logic [7:0]  diff;
    logic [3:0]  ones;
    logic [31:0] idx_full;
    diff = in_data.sent_byte ^ in_data.received_byte;
    ones = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      ones = ones + {3'b0, diff[i]};
    end
    idx_full = 32'(int'(in_data.user) * FRAME_WINDOW + int'(in_data.win_slot));

    q_data.op      = in_data.operation;
    q_data.user_ok = int'(in_data.user) < USERS;
    q_data.slot_ok = q_data.user_ok && (int'(in_data.win_slot) < FRAME_WINDOW);
    q_data.blk_err = in_data.amount != '0;
    q_data.uidx    = q_data.user_ok ? UIDX_W'(in_data.user) : '0;
    q_data.idx     = q_data.slot_ok ? idx_full[IDX_W-1:0] : '0;
    q_data.flipped = (in_data.operation == OP_BIT_ERR) ? ones : '0;
    case (in_data.operation)
      OP_BIT_ERR:  q_data.addend = {{(ADD_W-4){1'b0}}, ones};
      OP_DEC_BITS: q_data.addend = in_data.amount;
      OP_BLK_ERR:  q_data.addend = in_data.amount;
      OP_DEC_BLK:  q_data.addend = {{(ADD_W-SPB_W){1'b0}}, spb_r};
      default:     q_data.addend = '0;
    endcase
  end

endmodule

// ===== src/lesc_cmd_fifo.sv =====
module lesc_cmd_fifo import lesc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(CMDQ_DEPTH + 1);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = cnt_r == CNT_W_Q'(CMDQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/lesc_res_fifo.sv =====
module lesc_res_fifo import lesc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      full,
  input  logic      pop,
  output out_item_t pop_data,
  output logic      empty
);

  localparam int PTR_W = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(RESQ_DEPTH + 1);

  out_item_t          mem_r [RESQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = cnt_r == CNT_W_Q'(RESQ_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/lesc_back.sv =====
module lesc_back import lesc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      q_data,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      res_push,
  output out_item_t res_data,
  input  logic      res_full
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  cmd_t cmd_r;

  // Frame stores; a clearing pass after reset zeroes every entry
  logic [CNT_W-1:0] be_mem [SLOTS];
  logic [CNT_W-1:0] bt_mem [SLOTS];
  logic [CNT_W-1:0] se_mem [SLOTS];
  logic [CNT_W-1:0] st_mem [SLOTS];
  logic [CNT_W-1:0] be_q, bt_q, se_q, st_q;

  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;

  logic [CNT_W-1:0] ube_r [USERS];
  logic [CNT_W-1:0] ubt_r [USERS];

  logic             issue, exec;
  logic [CNT_W-1:0] be_old, bt_old, se_old, st_old, ube_old, ubt_old;
  logic [CNT_W-1:0] upd_old, upd_sum;
  logic             we_be, we_bt, we_se, we_st, clr_bit, clr_sym;
  logic             inc_ube, inc_ubt;

  assign issue = (state_r == ST_IDLE) && !clr_busy_r && !q_empty && !res_full;
  assign exec  = state_r == ST_EXEC;
  assign q_pop = issue;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (issue) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sweep one entry per cycle after reset; hold commands until done
  assign clr_busy_nxt = clr_busy_r && (clr_idx_r != IDX_W'(SLOTS - 1));
  assign clr_idx_nxt  = clr_busy_r ? clr_idx_r + 1'b1 : clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Read all four stores at issue; data is registered
  always_ff @(posedge clk) begin
    if (issue) begin
      cmd_r <= q_data;
      be_q  <= be_mem[q_data.idx];
      bt_q  <= bt_mem[q_data.idx];
      se_q  <= se_mem[q_data.idx];
      st_q  <= st_mem[q_data.idx];
    end
  end

  assign be_old  = be_q;
  assign bt_old  = bt_q;
  assign se_old  = se_q;
  assign st_old  = st_q;
  assign ube_old = ube_r[cmd_r.uidx];
  assign ubt_old = ubt_r[cmd_r.uidx];

  assign we_be   = exec && cmd_r.slot_ok && (cmd_r.op == OP_BIT_ERR);
  assign we_bt   = exec && cmd_r.slot_ok && (cmd_r.op == OP_DEC_BITS);
  assign we_se   = exec && cmd_r.slot_ok && (cmd_r.op == OP_BLK_ERR);
  assign we_st   = exec && cmd_r.slot_ok && (cmd_r.op == OP_DEC_BLK);
  assign clr_bit = exec && cmd_r.slot_ok && (cmd_r.op == OP_REP_BITS);
  assign clr_sym = exec && cmd_r.slot_ok && (cmd_r.op == OP_REP_SYMS);
  assign inc_ube = exec && cmd_r.user_ok && cmd_r.blk_err && (cmd_r.op == OP_BLK_ERR);
  assign inc_ubt = exec && cmd_r.user_ok && (cmd_r.op == OP_DEC_BLK);

  always_comb begin
    case (cmd_r.op)
      OP_BIT_ERR:  upd_old = be_old;
      OP_DEC_BITS: upd_old = bt_old;
      OP_BLK_ERR:  upd_old = se_old;
      OP_DEC_BLK:  upd_old = st_old;
      default:     upd_old = '0;
    endcase
  end

  assign upd_sum = sat_add(upd_old, cmd_r.addend);

  // Write back the update, zero the slot on report, or sweep after reset
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      be_mem[clr_idx_r] <= '0;
      bt_mem[clr_idx_r] <= '0;
      se_mem[clr_idx_r] <= '0;
      st_mem[clr_idx_r] <= '0;
    end else begin
      if (we_be || clr_bit) be_mem[cmd_r.idx] <= clr_bit ? '0 : upd_sum;
      if (we_bt || clr_bit) bt_mem[cmd_r.idx] <= clr_bit ? '0 : upd_sum;
      if (we_se || clr_sym) se_mem[cmd_r.idx] <= clr_sym ? '0 : upd_sum;
      if (we_st || clr_sym) st_mem[cmd_r.idx] <= clr_sym ? '0 : upd_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int u = 0; u < USERS; u++) begin
        ube_r[u] <= '0;
        ubt_r[u] <= '0;
      end
    end else begin
      if (inc_ube) ube_r[cmd_r.uidx] <= sat_add(ube_old, ADD_W'(1));
      if (inc_ubt) ubt_r[cmd_r.uidx] <= sat_add(ubt_old, ADD_W'(1));
    end
  end

  assign res_push = exec;

  always_comb begin
    res_data.error_count  = '0;
    res_data.total_count  = '0;
    res_data.flipped_bits = cmd_r.flipped;
    case (cmd_r.op)
      OP_REP_BITS: begin
        if (cmd_r.slot_ok) begin
          res_data.error_count = be_old;
          res_data.total_count = bt_old;
        end
      end
      OP_REP_SYMS: begin
        if (cmd_r.slot_ok) begin
          res_data.error_count = se_old;
          res_data.total_count = st_old;
        end
      end
      OP_REP_TOTAL: begin
        if (cmd_r.user_ok) begin
          res_data.error_count = ube_old;
          res_data.total_count = ubt_old;
        end
      end
      default: begin
        res_data.error_count = '0;
      end
    endcase
  end

  a_room_at_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> !res_full)
    else $error("result queue full while a result is pushed");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_IDLE)
    else $error("execute state held past one cycle");

  a_one_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({we_be, we_bt, we_se, we_st, clr_bit, clr_sym}))
    else $error("more than one frame store touched by one command");

  a_flipped_only_bit_err: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (cmd_r.op != OP_BIT_ERR) |-> res_data.flipped_bits == '0)
    else $error("flipped bits reported for a non bit-error operation");

  a_no_issue_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !q_pop)
    else $error("command taken during the clearing pass");

endmodule

// ===== src/link_error_statistics_counter_top.sv =====
// Link error statistics counter: per-user, per-frame-slot error counters.
//
// Input channel (in_push / in_full / in_data): one beat is one operation
// (bit errors, decoded bits, block errors, decoded block, or one of three
// reports). Result channel (out_empty / out_pop / out_data): exactly one
// result beat per input beat, in input order; the oldest result is shown
// while out_empty is low and is taken when out_pop is high.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes
// symbols_per_block; cfg_ready is always high. Write only while idle.
//
// A beat passes the command queue, the back end's registered store read
// and the result queue on its way to the output. The back end reads the
// addressed entry when it takes a command and writes the updated,
// saturated count back before it takes the next. A two-entry command
// queue lets the front accept beats while the back end works or stalls.
// Reset (rst_n low, synchronous): the back end then zeroes all 256 frame
// slots in a clearing pass; two beats queue meanwhile, after which
// in_full stays high until the pass ends.
// Receiver stall: results collect in a two-entry output queue; when it is
// full the back end holds, then the command queue fills and in_full rises.
module link_error_statistics_counter_top import lesc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_item_t         in_data,
  output logic             in_full,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SPB_W-1:0] cfg_data
);

  // Front to command queue
  logic q_push, q_full;
  cmd_t q_in;
  // Command queue to back end
  logic q_pop, q_empty;
  cmd_t q_out;
  // Back end to result queue
  logic      res_push, res_full;
  out_item_t res_data;

  // Classify the beat and hold the configuration register
  lesc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  // Decouple front and back
  lesc_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Read-modify-write the counter stores and build the result
  lesc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full)
  );

  // Hold results until the receiver pops them
  lesc_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

// ===== tb/testbench.sv =====
// Scoreboard for the link error statistics counter: mirrors every counter
// store and queues one expected result beat per accepted operation.
class counter_board;
  bit [31:0] bit_err_cnt [lesc_pkg::SLOTS];
  bit [31:0] bit_tot_cnt [lesc_pkg::SLOTS];
  bit [31:0] sym_err_cnt [lesc_pkg::SLOTS];
  bit [31:0] sym_tot_cnt [lesc_pkg::SLOTS];
  bit [31:0] blk_err_cnt [lesc_pkg::USERS];
  bit [31:0] blk_tot_cnt [lesc_pkg::USERS];
  bit [lesc_pkg::SPB_W-1:0] symbols_per_block;
  lesc_pkg::out_item_t expected_counts[$];
  int unsigned errors;

  function bit [31:0] clamp_sum(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Apply one operation to the mirrored stores and queue its result.
  function void note_operation(lesc_pkg::in_item_t op_in);
    lesc_pkg::out_item_t want;
    bit [7:0] diff;
    bit [3:0] flips;
    bit user_ok;
    bit slot_ok;
    int idx;
    want = '0;
    flips = '0;
    diff = op_in.sent_byte ^ op_in.received_byte;
    user_ok = op_in.user < lesc_pkg::USERS;
    slot_ok = user_ok && (op_in.win_slot < lesc_pkg::FRAME_WINDOW);
    idx = slot_ok ? op_in.user * lesc_pkg::FRAME_WINDOW + op_in.win_slot : 0;
    case (op_in.operation)
      lesc_pkg::OP_BIT_ERR: begin
        for (int i = 0; i < 8; i++) flips += {3'b0, diff[i]};
        if (slot_ok) bit_err_cnt[idx] = clamp_sum(bit_err_cnt[idx], 32'(flips));
      end
      lesc_pkg::OP_DEC_BITS: begin
        if (slot_ok) bit_tot_cnt[idx] = clamp_sum(bit_tot_cnt[idx], 32'(op_in.amount));
      end
      lesc_pkg::OP_BLK_ERR: begin
        if (user_ok && op_in.amount != 0)
          blk_err_cnt[op_in.user] = clamp_sum(blk_err_cnt[op_in.user], 32'd1);
        if (slot_ok) sym_err_cnt[idx] = clamp_sum(sym_err_cnt[idx], 32'(op_in.amount));
      end
      lesc_pkg::OP_DEC_BLK: begin
        if (user_ok) blk_tot_cnt[op_in.user] = clamp_sum(blk_tot_cnt[op_in.user], 32'd1);
        if (slot_ok)
          sym_tot_cnt[idx] = clamp_sum(sym_tot_cnt[idx], 32'(symbols_per_block));
      end
      lesc_pkg::OP_REP_BITS: begin
        if (slot_ok) begin
          want.error_count = bit_err_cnt[idx];
          want.total_count = bit_tot_cnt[idx];
          bit_err_cnt[idx] = 0;
          bit_tot_cnt[idx] = 0;
        end
      end
      lesc_pkg::OP_REP_SYMS: begin
        if (slot_ok) begin
          want.error_count = sym_err_cnt[idx];
          want.total_count = sym_tot_cnt[idx];
          sym_err_cnt[idx] = 0;
          sym_tot_cnt[idx] = 0;
        end
      end
      lesc_pkg::OP_REP_TOTAL: begin
        if (user_ok) begin
          want.error_count = blk_err_cnt[op_in.user];
          want.total_count = blk_tot_cnt[op_in.user];
        end
      end
      default: ;
    endcase
    want.flipped_bits = flips;
    expected_counts.push_back(want);
  endfunction

  function void flag(string field, longint unsigned want, logic [31:0] got);
    errors++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  function void check_result(lesc_pkg::out_item_t got);
    lesc_pkg::out_item_t want;
    if (expected_counts.size() == 0) begin
      errors++;
      $error("result beat with no operation pending");
      return;
    end
    want = expected_counts.pop_front();
    if (got.error_count !== want.error_count)
      flag("error_count", want.error_count, got.error_count);
    if (got.total_count !== want.total_count)
      flag("total_count", want.total_count, got.total_count);
    if (got.flipped_bits !== want.flipped_bits)
      flag("flipped_bits", want.flipped_bits, got.flipped_bits);
  endfunction
endclass

module testbench;
  import lesc_pkg::*;

  // Opcode the block leaves unused; it must answer with all-zero fields.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  // Receiver hold-off used to fill the command and result queues.
  localparam int LONG_HOLD = 300;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Rounds of large adds onto one slot in the final stretch.
  localparam int TAIL_ROUNDS = 8;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 290;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  in_item_t         in_data = '0;
  logic             in_full;
  logic             out_empty;
  logic             out_pop = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SPB_W-1:0] cfg_data = '0;

  // Idle rates in percent per beat for each side; quiet_tail stops all idling.
  int unsigned push_gap_pct = 20;
  int unsigned pop_gap_pct = 15;
  bit          quiet_tail = 1'b0;
  // Set by the stimulus; the receiver process picks it up and holds off.
  bit          hold_request = 1'b0;
  int unsigned stall_cycles = 0;

  counter_board board = new();

  link_error_statistics_counter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Monitor: sample every handshake at the rising edge, where all inputs
  // still hold their pre-edge values (they are driven with nonblocking
  // assignments). Apply the register write first, then the input beat, then
  // check the result beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.symbols_per_block = cfg_data;
      if (in_push && !in_full) board.note_operation(in_data);
      if (out_pop && !out_empty) board.check_result(out_data);
      if ((cfg_valid && cfg_ready) || (in_push && !in_full) || (out_pop && !out_empty))
        stall_cycles = 0;
      else
        stall_cycles++;
      // Bail out if no beat moved for far longer than any legal stall.
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: drive out_pop once per loop pass, so each time step sees at
  // most one assignment. Honor a long hold request first, else idle in
  // random bursts, else pop.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 99) < pop_gap_pct) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one operation beat and hold it until the block takes it. Leave
  // in_push high on return so back-to-back beats need no extra assignment.
  task automatic send_item(input in_item_t op_in);
    if (!quiet_tail && $urandom_range(0, 99) < push_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= op_in;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result beat has come back,
  // then let the pipeline settle before touching the register.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_spb(input logic [SPB_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_op(logic [2:0] op, logic [3:0] user,
                                       logic [3:0] slot, logic [7:0] sent,
                                       logic [7:0] recv, logic [15:0] amount);
    in_item_t op_in;
    op_in.operation     = op;
    op_in.user          = user;
    op_in.win_slot      = slot;
    op_in.sent_byte     = sent;
    op_in.received_byte = recv;
    op_in.amount        = amount;
    return op_in;
  endfunction

  // Random operation: mostly updates, about a third reports. Keep most
  // traffic on a few users and slots so reports see real accumulated counts.
  function automatic in_item_t random_item();
    in_item_t op_in;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 20)      op_in.operation = OP_BIT_ERR;
    else if (sel < 35) op_in.operation = OP_DEC_BITS;
    else if (sel < 50) op_in.operation = OP_BLK_ERR;
    else if (sel < 65) op_in.operation = OP_DEC_BLK;
    else if (sel < 77) op_in.operation = OP_REP_BITS;
    else if (sel < 89) op_in.operation = OP_REP_SYMS;
    else if (sel < 97) op_in.operation = OP_REP_TOTAL;
    else               op_in.operation = OP_UNUSED;
    op_in.user     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 2));
    op_in.win_slot = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 2));
    op_in.sent_byte  = 8'($urandom);
    op_in.received_byte = ($urandom_range(0, 3) == 0) ? op_in.sent_byte : 8'($urandom);
    case ($urandom_range(0, 3))
      0:       op_in.amount = '0;
      1:       op_in.amount = '1;
      2:       op_in.amount = 16'($urandom_range(0, 15));
      default: op_in.amount = 16'($urandom);
    endcase
    return op_in;
  endfunction

  initial begin
    logic [SPB_W-1:0] spb_value;
    // Hold reset low, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: largest block size, then field extremes and every opcode.
    write_spb('1);
    send_item(make_op(OP_BIT_ERR,   4'd0,  4'd0,  8'hFF, 8'h00, 16'h0000));
    send_item(make_op(OP_BIT_ERR,   4'd0,  4'd0,  8'hA5, 8'hA5, 16'hFFFF));
    send_item(make_op(OP_DEC_BITS,  4'd0,  4'd0,  8'h00, 8'hFF, 16'hFFFF));
    send_item(make_op(OP_REP_BITS,  4'd0,  4'd0,  8'h00, 8'h00, 16'h0000));
    // Report again: the counters must have been cleared by the first report.
    send_item(make_op(OP_REP_BITS,  4'd0,  4'd0,  8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_BLK_ERR,   4'd1,  4'd15, 8'h00, 8'h00, 16'hFFFF));
    // A block error of zero leaves every counter untouched.
    send_item(make_op(OP_BLK_ERR,   4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_DEC_BLK,   4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_SYMS,  4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_TOTAL, 4'd1,  4'd0,  8'h00, 8'h00, 16'h0000));
    // Unused opcode with every other field at its maximum.
    send_item(make_op(OP_UNUSED,    4'd15, 4'd15, 8'hFF, 8'hFF, 16'hFFFF));
    send_item(make_op(OP_BIT_ERR,   4'd15, 4'd15, 8'h0F, 8'hF0, 16'h0000));
    send_item(make_op(OP_DEC_BLK,   4'd15, 4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_TOTAL, 4'd15, 4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_BITS,  4'd15, 4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_SYMS,  4'd15, 4'd15, 8'h00, 8'h00, 16'h0000));
    drain();
    // Zero block size: a decoded block adds nothing to the symbol total.
    write_spb('0);
    send_item(make_op(OP_DEC_BLK,   4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_SYMS,  4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_TOTAL, 4'd1,  4'd15, 8'h00, 8'h00, 16'h0000));
    drain();

    // Random phases, each under its own block size and idle mix.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       spb_value = '0;
        1:       spb_value = '1;
        default: spb_value = $urandom_range(1, 4094);
      endcase
      push_gap_pct = (phase == 2) ? 0 : $urandom_range(5, 40);
      pop_gap_pct  = (phase == 2) ? 0 : $urandom_range(5, 40);
      write_spb(spb_value);
      // Stall the receiver long enough to fill both queues and raise in_full.
      if (phase == 3) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_item(random_item());
      drain();
    end

    // Final stretch, no idling: pile large adds onto one slot's bit total
    // and symbol error counters, then report them.
    quiet_tail = 1'b1;
    write_spb('1);
    for (int i = 0; i < TAIL_ROUNDS; i++) begin
      send_item(make_op(OP_DEC_BITS, 4'd2, 4'd9, 8'h00, 8'h00, 16'hFFFF));
      send_item(make_op(OP_BLK_ERR,  4'd2, 4'd9, 8'h00, 8'h00, 16'hFFFF));
    end
    send_item(make_op(OP_BIT_ERR,   4'd2, 4'd9, 8'hFF, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_BITS,  4'd2, 4'd9, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_SYMS,  4'd2, 4'd9, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_TOTAL, 4'd2, 4'd9, 8'h00, 8'h00, 16'h0000));
    send_item(make_op(OP_REP_BITS,  4'd2, 4'd9, 8'h00, 8'h00, 16'h0000));
    repeat (40) send_item(random_item());
    drain();

    if (board.errors == 0 && board.expected_counts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
